// File: rtl/feb_pkg.sv
// ----------------------------------------------------------------------------
// feb_pkg
// Shared types, cipher tables and the round function of the Feistel encryptor.
// ----------------------------------------------------------------------------
package feb_pkg;

    localparam int ROUNDS    = 10;
    localparam int KEY_W     = 32;
    localparam int HALF_W    = 32;
    localparam int BLOCK_W   = 64;
    localparam int S_DATA_W  = 96;
    localparam int M_DATA_W  = 64;

    // working set carried from cell to cell
    typedef struct packed {
        logic [KEY_W-1:0]  key;
        logic [HALF_W-1:0] l;
        logic [HALF_W-1:0] r;
    } t_cell;

    localparam logic [3:0] SBOX1 [16] = '{
        4'hE, 4'h4, 4'hD, 4'h1, 4'h2, 4'hF, 4'hB, 4'h8,
        4'h3, 4'hA, 4'h6, 4'hC, 4'h5, 4'h9, 4'h0, 4'h7
    };
    localparam logic [3:0] SBOX2 [16] = '{
        4'h5, 4'h6, 4'hC, 4'hF, 4'h8, 4'hA, 4'h0, 4'h4,
        4'hB, 4'h3, 4'h7, 4'hD, 4'hE, 4'h1, 4'h2, 4'h9
    };
    // destination of each bit, both positions counted from the msb
    localparam logic [4:0] PERM [32] = '{
        5'd29, 5'd1,  5'd17, 5'd8,  5'd30, 5'd22, 5'd28, 5'd6,
        5'd18, 5'd4,  5'd12, 5'd19, 5'd21, 5'd26, 5'd2,  5'd20,
        5'd31, 5'd10, 5'd9,  5'd25, 5'd13, 5'd0,  5'd23, 5'd15,
        5'd3,  5'd27, 5'd5,  5'd11, 5'd7,  5'd14, 5'd24, 5'd16
    };

    // rotate both 16-bit key halves left by one
    function automatic logic [KEY_W-1:0] rot_halves(input logic [KEY_W-1:0] k);
        rot_halves = {k[30:16], k[31], k[14:0], k[15]};
    endfunction

    function automatic logic [HALF_W-1:0] round_fn(input logic [HALF_W-1:0] r,
                                                   input logic [KEY_W-1:0]  k);
        logic [HALF_W-1:0] x;
        logic [HALF_W-1:0] s;
        logic [HALF_W-1:0] p;
        logic [4:0]        dst;
        x = r ^ k;
        s = '0;
        p = '0;
        // nibble i counted from the msb; even ones use sbox1
        for (int i = 0; i < 8; i++) begin
            if (i % 2 == 0) begin
                s[28-4*i +: 4] = SBOX1[x[28-4*i +: 4]];
            end else begin
                s[28-4*i +: 4] = SBOX2[x[28-4*i +: 4]];
            end
        end
        for (int i = 0; i < 32; i++) begin
            dst = 5'd31 - PERM[i];
            p[dst] = s[31-i];
        end
        round_fn = p;
    endfunction

endpackage

// File: rtl/feb_cell.sv
// ----------------------------------------------------------------------------
// feb_cell
// One cipher round with its output register and a valid/ready link.
// ----------------------------------------------------------------------------
module feb_cell (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  feb_pkg::t_cell i_data,
    output logic           o_ready,
    output logic           o_valid,
    output feb_pkg::t_cell o_data,
    input  logic           i_ready
);
    import feb_pkg::*;

    logic  r_valid;
    t_cell r_data;
    t_cell n_data;
    logic  [KEY_W-1:0] rkey;

    assign rkey       = rot_halves(i_data.key);
    assign n_data.key = rkey;
    assign n_data.l   = i_data.r;
    assign n_data.r   = i_data.l ^ round_fn(i_data.r, rkey);

    // register may take a new request when empty or when its content moves on
    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

// File: rtl/feistel_block_encrypt_top.sv
// ----------------------------------------------------------------------------
// feistel_block_encrypt_top
// 64-bit Feistel encryptor, one round per cell, one block per cycle while the output is drained.
// ----------------------------------------------------------------------------
// channel  | dir | tdata bits (lowest first)
// s_axis   | in  | key_word[31:0], plain_block[95:32]
// m_axis   | out | cipher_block[63:0]
//
// one register per round cell
// a new request is taken every cycle while the output is drained
// ready ripples back through the cells, so bubbles are filled under stall
// the last cell register is the output register
// synchronous active-low reset clears the valid bits only
// ----------------------------------------------------------------------------
module feistel_block_encrypt_top (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    input  logic [feb_pkg::S_DATA_W-1:0]    i_s_tdata,  // key_word, plain_block
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    output logic [feb_pkg::M_DATA_W-1:0]    o_m_tdata   // cipher_block
);
    import feb_pkg::*;

    logic  vld [ROUNDS+1];
    logic  rdy [ROUNDS+1];
    t_cell dat [ROUNDS+1];

    assign vld[0]     = i_s_tvalid;
    assign dat[0].key = i_s_tdata[KEY_W-1:0];
    assign dat[0].l   = i_s_tdata[KEY_W+BLOCK_W-1 -: HALF_W];
    assign dat[0].r   = i_s_tdata[KEY_W +: HALF_W];
    assign o_s_tready = rdy[0];

    for (genvar g = 0; g < ROUNDS; g++) begin : g_cell
        feb_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (vld[g]),
            .i_data  (dat[g]),
            .o_ready (rdy[g]),
            .o_valid (vld[g+1]),
            .o_data  (dat[g+1]),
            .i_ready (rdy[g+1])
        );
    end

    assign rdy[ROUNDS] = i_m_tready;
    assign o_m_tvalid  = vld[ROUNDS];
    assign o_m_tdata   = {dat[ROUNDS].r, dat[ROUNDS].l};

    // an empty output means the whole chain can take a request
    a_empty_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_m_tvalid |-> o_s_tready)
        else $error("input stalled with empty output");

    a_ready_pass: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tready |-> o_s_tready)
        else $error("ready not passed back through cells");

    a_first_cell: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> vld[1])
        else $error("accepted request lost in first cell");

    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("output valid after reset");

endmodule
